FILE: rtl/pal_pkg.sv
package pal_pkg;

    // field widths of the item and result channels
    localparam int FUNC_W = 3;
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 6;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_INSERT  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ERASE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_APPEND  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_POP     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ    = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SEARCH  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_CLEAR   = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SET_LEN = 3'd7;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    // first entry reported for an empty list
    localparam logic signed [DATA_W-1:0] EMPTY_FIRST = -32'sd1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch a new item
        logic exec;      // run the operation on the cell row
        logic load;      // load the result register
    } t_cmd;

endpackage

FILE: rtl/pal_req_if.sv
interface pal_req_if;

    logic                                  valid;
    logic                                  ready;
    logic [pal_pkg::FUNC_W-1:0]            func;
    logic [pal_pkg::POS_W-1:0]             position;
    logic signed [pal_pkg::DATA_W-1:0]     value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);

endinterface

FILE: rtl/pal_rsp_if.sv
interface pal_rsp_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [pal_pkg::DATA_W-1:0]     read_value;
    logic                                  found;
    logic [pal_pkg::ST_W-1:0]              status;
    logic [pal_pkg::LEN_W-1:0]             length;
    logic                                  is_empty;
    logic signed [pal_pkg::DATA_W-1:0]     first_value;
    logic signed [pal_pkg::DATA_W-1:0]     last_value;

    modport source (output valid, output read_value, output found, output status,
                    output length, output is_empty, output first_value,
                    output last_value, input ready);
    modport sink   (input valid, input read_value, input found, input status,
                    input length, input is_empty, input first_value,
                    input last_value, output ready);

endinterface

FILE: rtl/pal_ctrl.sv
module pal_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pal_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       slot_free;
    logic       accept;

    // result register can take a new result
    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_FINISH) && slot_free);
    assign accept     = i_in_valid && o_in_ready;

    // datapath commands
    always_comb begin
        o_cmd.capture = accept;
        o_cmd.exec    = (r_state == S_EXEC);
        o_cmd.load    = (r_state == S_FINISH) && slot_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (slot_free) n_state = accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: rtl/pal_dp.sv
module pal_dp #(
    parameter int DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pal_pkg::t_cmd                        i_cmd,
    input  logic [pal_pkg::FUNC_W-1:0]           i_func,
    input  logic [pal_pkg::POS_W-1:0]            i_position,
    input  logic signed [pal_pkg::DATA_W-1:0]    i_value,
    output logic signed [pal_pkg::DATA_W-1:0]    o_read_value,
    output logic                                 o_found,
    output logic [pal_pkg::ST_W-1:0]             o_status,
    output logic [pal_pkg::LEN_W-1:0]            o_length,
    output logic                                 o_is_empty,
    output logic signed [pal_pkg::DATA_W-1:0]    o_first_value,
    output logic signed [pal_pkg::DATA_W-1:0]    o_last_value
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > pal_pkg::POS_W) ? CW : pal_pkg::POS_W;
    localparam int IW = $clog2(DEPTH);

    // latched item
    logic [pal_pkg::FUNC_W-1:0]         r_func;
    logic [pal_pkg::POS_W-1:0]          r_pos;
    logic signed [pal_pkg::DATA_W-1:0]  r_val;

    // list state: cell row and length
    logic signed [pal_pkg::DATA_W-1:0]  r_cells [DEPTH];
    logic signed [pal_pkg::DATA_W-1:0]  n_cells [DEPTH];
    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      n_count;
    logic [pal_pkg::ST_W-1:0]           r_status;
    logic [pal_pkg::ST_W-1:0]           n_status;
    logic [DEPTH-1:0]                   r_match;
    logic [DEPTH-1:0]                   n_match;

    // result register
    logic signed [pal_pkg::DATA_W-1:0]  r_o_read;
    logic                               r_o_found;
    logic [pal_pkg::ST_W-1:0]           r_o_status;
    logic [pal_pkg::LEN_W-1:0]          r_o_length;
    logic                               r_o_empty;
    logic signed [pal_pkg::DATA_W-1:0]  r_o_first;
    logic signed [pal_pkg::DATA_W-1:0]  r_o_last;

    logic [KW-1:0] n_k;
    logic [KW-1:0] p_k;
    logic [KW-1:0] depth_k;
    logic          ins_ok;
    logic          ers_ok;
    logic          app_ok;
    logic [CW-1:0] last_idx;

    assign n_k     = KW'(r_count);
    assign p_k     = KW'(r_pos);
    assign depth_k = KW'(DEPTH);
    assign ins_ok  = (p_k <= n_k) && (n_k < depth_k);
    assign ers_ok  = (p_k < n_k);
    assign app_ok  = (n_k < depth_k);

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_pos  <= i_position;
            r_val  <= i_value;
        end
    end

    // new length and status
    always_comb begin
        n_count  = r_count;
        n_status = pal_pkg::ST_OK;
        unique case (r_func)
            pal_pkg::FN_INSERT: begin
                if (p_k > n_k) n_status = pal_pkg::ST_RANGE;
                else if (!app_ok) n_status = pal_pkg::ST_FULL;
                else n_count = r_count + CW'(1);
            end
            pal_pkg::FN_ERASE: begin
                if (!ers_ok) n_status = pal_pkg::ST_RANGE;
                else n_count = r_count - CW'(1);
            end
            pal_pkg::FN_APPEND: begin
                if (!app_ok) n_status = pal_pkg::ST_FULL;
                else n_count = r_count + CW'(1);
            end
            pal_pkg::FN_POP: begin
                if (r_count == '0) n_status = pal_pkg::ST_EMPTY;
                else n_count = r_count - CW'(1);
            end
            pal_pkg::FN_READ: begin
                if (!ers_ok) n_status = pal_pkg::ST_RANGE;
            end
            pal_pkg::FN_CLEAR: begin
                n_count = '0;
            end
            pal_pkg::FN_SET_LEN: begin
                if (p_k > depth_k) begin
                    n_count  = CW'(DEPTH);
                    n_status = pal_pkg::ST_RANGE;
                end else begin
                    n_count = CW'(p_k);
                end
            end
            default: begin
            end
        endcase
    end

    // per-cell shift, write and compare
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_cells[i] = r_cells[i];
            n_match[i] = (r_func == pal_pkg::FN_SEARCH) && (KW'(i) < n_k)
                         && (r_cells[i] == r_val);
            unique case (r_func)
                pal_pkg::FN_INSERT: begin
                    if (ins_ok) begin
                        if (KW'(i) == p_k) n_cells[i] = r_val;
                        else if ((KW'(i) > p_k) && (KW'(i) <= n_k))
                            n_cells[i] = r_cells[(i == 0) ? 0 : i - 1];
                    end
                end
                pal_pkg::FN_ERASE: begin
                    if (ers_ok && (KW'(i) >= p_k) && (KW'(i + 1) < n_k))
                        n_cells[i] = r_cells[(i == DEPTH - 1) ? i : i + 1];
                end
                pal_pkg::FN_APPEND: begin
                    if (app_ok && (KW'(i) == n_k)) n_cells[i] = r_val;
                end
                default: begin
                end
            endcase
        end
    end

    // cell row, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) r_cells[i] <= '0;
        end else if (i_cmd.exec) begin
            for (int i = 0; i < DEPTH; i++) r_cells[i] <= n_cells[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_match  <= n_match;
        end
    end

    // result register: read port, last-entry tap and flags
    assign last_idx = r_count - CW'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_found  <= |r_match;
            r_o_status <= r_status;
            r_o_length <= pal_pkg::LEN_W'(r_count);
            r_o_empty  <= (r_count == '0);
            if ((r_func == pal_pkg::FN_READ) && (r_status == pal_pkg::ST_OK))
                r_o_read <= r_cells[p_k[IW-1:0]];
            else
                r_o_read <= '0;
            if (r_count == '0) begin
                r_o_first <= pal_pkg::EMPTY_FIRST;
                r_o_last  <= '0;
            end else begin
                r_o_first <= r_cells[0];
                r_o_last  <= r_cells[last_idx[IW-1:0]];
            end
        end
    end

    assign o_read_value  = r_o_read;
    assign o_found       = r_o_found;
    assign o_status      = r_o_status;
    assign o_length      = r_o_length;
    assign o_is_empty    = r_o_empty;
    assign o_first_value = r_o_first;
    assign o_last_value  = r_o_last;

endmodule

FILE: rtl/positional_array_list_top.sv
// Positional array list: an ordered list of up to DEPTH signed 32-bit entries and a
// length, kept in a row of registers that shifts all later entries in one step on insert
// and erase. Each request carries insert, erase, append, remove last, read, search, clear
// or set length, and returns exactly one response with the read value, found flag,
// status, new length, empty flag and first and last entries. A request is handled in an
// execute step, in which the cell row shifts and the length and per-cell search compares
// are registered, and a finish step, in which the read and last-entry selects and the
// found OR load the response register; the next request can be taken in the finish step
// while the response register is free or its response is being taken. Bad positions,
// overflow and underflow are reported in status and leave the list unchanged, but a set
// length beyond DEPTH clamps the length to DEPTH. All entries are zero after reset.
module positional_array_list_top #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pal_req_if.sink     i_req,
    pal_rsp_if.source   o_rsp
);

    pal_pkg::t_cmd cmd;

    pal_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    pal_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_func        (i_req.func),
        .i_position    (i_req.position),
        .i_value       (i_req.value),
        .o_read_value  (o_rsp.read_value),
        .o_found       (o_rsp.found),
        .o_status      (o_rsp.status),
        .o_length      (o_rsp.length),
        .o_is_empty    (o_rsp.is_empty),
        .o_first_value (o_rsp.first_value),
        .o_last_value  (o_rsp.last_value)
    );

endmodule
